@@ sv/scra_pkg.sv @@
// Shared types, constants and mode helpers for the capture readout address generator.
package scra_pkg;

  localparam int BUFFER_DEPTH      = 32768;
  localparam int LONG_SEG_DEPTH    = 4096;
  localparam int SHORT_SEG_DEPTH   = 1024;
  localparam int SAMPLES_PER_CLOCK = 8;
  localparam int MAX_WORDS         = 64;
  localparam int LATENCY_LOSS      = 14;

  localparam int ADDR_W   = 15;
  localparam int START_W  = 15;
  localparam int OFF_W    = 16;
  localparam int WORDS_W  = 7;
  localparam int MODE_W   = 2;
  localparam int PRE_W    = 15;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int SEG_W    = 6;
  localparam int IDX_W    = $clog2(LONG_SEG_DEPTH);
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W  = 15;
  localparam int PROD_W   = START_W + RECIP_W;
  localparam int SPS_W    = 13;

  localparam int LONG_SPS    = LONG_SEG_DEPTH - LATENCY_LOSS;
  localparam int SHORT_SPS   = SHORT_SEG_DEPTH - LATENCY_LOSS;
  localparam int LONG_RECIP  = (1 << RECIP_SHIFT) / LONG_SPS;
  localparam int SHORT_RECIP = (1 << RECIP_SHIFT) / SHORT_SPS;
  localparam int LONG_SHIFT  = $clog2(LONG_SEG_DEPTH);
  localparam int SHORT_SHIFT = $clog2(SHORT_SEG_DEPTH);
  localparam int CONTIG_LIMIT = BUFFER_DEPTH - LATENCY_LOSS;
  localparam int LONG_LIMIT   = LONG_SPS * (BUFFER_DEPTH / LONG_SEG_DEPTH);
  localparam int SHORT_LIMIT  = SHORT_SPS * (BUFFER_DEPTH / SHORT_SEG_DEPTH);
  localparam int PRE_MAX      = BUFFER_DEPTH - SAMPLES_PER_CLOCK;
  localparam int SEG_SKIP     = LATENCY_LOSS + 1;

  localparam logic [MODE_W-1:0] MODE_CONTIG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LONG   = 2'd1;

  localparam logic REG_SEG_MODE   = 1'b0;
  localparam logic REG_PRETRIGGER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  trigger_location;
    logic [START_W-1:0] start_offset;
    logic [OFF_W-1:0]   end_offset;
    logic [WORDS_W-1:0] max_words;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] read_address;
    logic              addr_valid;
    logic              beyond_limit;
    logic              last_result;
  } res_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } dp_status_t;

  function automatic logic [SPS_W-1:0] sps_of(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_LONG: sps_of = SPS_W'(LONG_SPS);
      default:   sps_of = SPS_W'(SHORT_SPS);
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] recip_of(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_LONG: recip_of = RECIP_W'(LONG_RECIP);
      default:   recip_of = RECIP_W'(SHORT_RECIP);
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] limit_of(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_CONTIG: limit_of = OFF_W'(CONTIG_LIMIT);
      MODE_LONG:   limit_of = OFF_W'(LONG_LIMIT);
      default:     limit_of = OFF_W'(SHORT_LIMIT);
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] seg_base_of(input logic [MODE_W-1:0] mode,
                                                   input logic [SEG_W-1:0] seg);
    case (mode)
      MODE_LONG: seg_base_of = OFF_W'({10'd0, seg} << LONG_SHIFT);
      default:   seg_base_of = OFF_W'({10'd0, seg} << SHORT_SHIFT);
    endcase
  endfunction

endpackage

@@ sv/scra_regs.sv @@
// Configuration register file: segment mode and clamped pretrigger count.
module scra_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scra_pkg::PADDR_W-1:0]   paddr,
  input  logic [scra_pkg::PDATA_W-1:0]   pwdata,
  output logic [scra_pkg::PDATA_W-1:0]   prdata,
  output logic [scra_pkg::MODE_W-1:0]    seg_mode,
  output logic [scra_pkg::PRE_W-1:0]     pretrigger_count
);

  logic                         wr;
  logic [scra_pkg::PRE_W-1:0]   pre_raw;
  logic [scra_pkg::PRE_W-1:0]   pretrigger_count_next;

  assign wr      = psel && penable && pwrite;
  assign pre_raw = pwdata[scra_pkg::PRE_W-1:0];

  always_comb begin
    if (pre_raw == '0) begin
      pretrigger_count_next = scra_pkg::PRE_W'(1);
    end else if (pre_raw > scra_pkg::PRE_W'(scra_pkg::PRE_MAX)) begin
      pretrigger_count_next = scra_pkg::PRE_W'(scra_pkg::PRE_MAX);
    end else begin
      pretrigger_count_next = pre_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_mode         <= scra_pkg::MODE_CONTIG;
      pretrigger_count <= scra_pkg::PRE_W'(1);
    end else if (wr) begin
      case (paddr[2])
        scra_pkg::REG_SEG_MODE:   seg_mode <= pwdata[scra_pkg::MODE_W-1:0];
        scra_pkg::REG_PRETRIGGER: pretrigger_count <= pretrigger_count_next;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      scra_pkg::REG_SEG_MODE:   prdata = scra_pkg::PDATA_W'(seg_mode);
      scra_pkg::REG_PRETRIGGER: prdata = scra_pkg::PDATA_W'(pretrigger_count);
      default:                  prdata = '0;
    endcase
  end

endmodule

@@ sv/scra_ctrl.sv @@
// Controller state machine: accept, segment split, address sequencing.
module scra_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output scra_pkg::ctrl_cmd_t   cmd,
  input  scra_pkg::dp_status_t  status
);

  scra_pkg::state_t state;
  scra_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      scra_pkg::ST_IDLE: begin
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = scra_pkg::ST_MUL;
        end
      end
      scra_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = scra_pkg::ST_FIX;
      end
      scra_pkg::ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = scra_pkg::ST_RUN;
      end
      scra_pkg::ST_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last) begin
            state_next = scra_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = scra_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result issued while output register busy");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last) |=> (state == scra_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after final result");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != scra_pkg::ST_IDLE) |-> in_stall)
    else $error("input accepted while a transaction is in progress");
`endif

endmodule

@@ sv/scra_dp.sv @@
// Datapath: base address, segment split, offset counters and output register.
module scra_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  scra_pkg::ctrl_cmd_t           cmd,
  output scra_pkg::dp_status_t          status,
  input  scra_pkg::req_t                in_data,
  input  logic [scra_pkg::MODE_W-1:0]   seg_mode,
  input  logic [scra_pkg::PRE_W-1:0]    pretrigger_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output scra_pkg::res_t                out_data
);

  logic [scra_pkg::ADDR_W-1:0]   base_address;
  logic [scra_pkg::OFF_W-1:0]    current_offset;
  logic [scra_pkg::OFF_W-1:0]    end_off;
  logic [scra_pkg::WORDS_W-1:0]  words_left;
  logic [scra_pkg::PROD_W-1:0]   prod;
  logic [scra_pkg::OFF_W-1:0]    buf_off;
  logic [scra_pkg::IDX_W-1:0]    index_in_segment;

  logic [scra_pkg::WORDS_W-1:0]  budget;
  logic [scra_pkg::SPS_W-1:0]    sps;
  logic [scra_pkg::OFF_W-1:0]    limit;
  logic [scra_pkg::SEG_W-1:0]    q_est;
  logic [scra_pkg::SEG_W-1:0]    q_fix;
  logic [scra_pkg::SEG_W+scra_pkg::SPS_W-1:0] q_prod;
  logic [scra_pkg::SPS_W-1:0]    rem_est;
  logic [scra_pkg::SPS_W-1:0]    rem_fix;
  logic                          rem_over;
  logic [scra_pkg::OFF_W-1:0]    next_offset;
  logic                          cur_cont;
  logic                          cur_inlim;
  logic                          next_cont;
  logic                          next_inlim;
  logic                          seg_wrap;
  scra_pkg::res_t                res_next;

  assign budget = (in_data.max_words > scra_pkg::WORDS_W'(scra_pkg::MAX_WORDS)) ?
                  scra_pkg::WORDS_W'(scra_pkg::MAX_WORDS) : in_data.max_words;
  assign sps    = scra_pkg::sps_of(seg_mode);
  assign limit  = scra_pkg::limit_of(seg_mode);

  assign q_est    = prod[scra_pkg::RECIP_SHIFT +: scra_pkg::SEG_W];
  assign q_prod   = q_est * sps;
  assign rem_est  = scra_pkg::SPS_W'(current_offset - scra_pkg::OFF_W'(q_prod));
  assign rem_over = rem_est >= sps;
  assign q_fix    = rem_over ? q_est + scra_pkg::SEG_W'(1) : q_est;
  assign rem_fix  = rem_over ? rem_est - sps : rem_est;

  assign next_offset = current_offset + scra_pkg::OFF_W'(1);
  assign cur_cont    = (words_left != '0) && (current_offset < end_off);
  assign cur_inlim   = current_offset < limit;
  assign next_cont   = (words_left > scra_pkg::WORDS_W'(1)) && (next_offset < end_off);
  assign next_inlim  = next_offset < limit;
  assign seg_wrap    = (seg_mode != scra_pkg::MODE_CONTIG) &&
                       (scra_pkg::SPS_W'(index_in_segment) == sps - scra_pkg::SPS_W'(1));

  always_comb begin
    res_next = '0;
    if (cur_cont && cur_inlim) begin
      res_next.read_address = base_address + buf_off[scra_pkg::ADDR_W-1:0];
      res_next.addr_valid   = 1'b1;
      res_next.beyond_limit = next_cont && !next_inlim;
      res_next.last_result  = !next_cont || !next_inlim;
    end else begin
      res_next.beyond_limit = cur_cont;
      res_next.last_result  = 1'b1;
    end
  end

  assign status.out_free = !out_valid || !out_stall;
  assign status.last     = res_next.last_result;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_address   <= in_data.trigger_location - pretrigger_count;
      current_offset <= scra_pkg::OFF_W'(in_data.start_offset);
      end_off        <= in_data.end_offset;
      words_left     <= budget;
    end else if (cmd.emit) begin
      current_offset <= next_offset;
      words_left     <= words_left - scra_pkg::WORDS_W'(1);
    end
    if (cmd.mul) begin
      prod <= current_offset[scra_pkg::START_W-1:0] * scra_pkg::recip_of(seg_mode);
    end
    if (cmd.fix) begin
      if (seg_mode == scra_pkg::MODE_CONTIG) begin
        buf_off          <= current_offset;
        index_in_segment <= '0;
      end else begin
        buf_off          <= scra_pkg::seg_base_of(seg_mode, q_fix) |
                            scra_pkg::OFF_W'(rem_fix);
        index_in_segment <= rem_fix[scra_pkg::IDX_W-1:0];
      end
    end else if (cmd.emit) begin
      if (seg_wrap) begin
        buf_off          <= buf_off + scra_pkg::OFF_W'(scra_pkg::SEG_SKIP);
        index_in_segment <= '0;
      end else begin
        buf_off          <= buf_off + scra_pkg::OFF_W'(1);
        index_in_segment <= index_in_segment + scra_pkg::IDX_W'(1);
      end
    end
    if (cmd.emit) begin
      out_data <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.addr_valid || out_data.last_result))
    else $error("invalid address not marked as final result");
  a_limit_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.beyond_limit) |-> out_data.last_result)
    else $error("limit flag on a non-final result");
  a_budget_left: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !res_next.last_result) |-> (words_left > scra_pkg::WORDS_W'(1)))
    else $error("sequence continues past word budget");
`endif

endmodule

@@ sv/segmented_capture_readout_address.sv @@
// Top level of the segmented capture readout address generator.
//
//   port group   direction  handshake             payload
//   in_*         in         in_valid / in_stall   scra_pkg::req_t
//   out_*        out        out_valid / out_stall scra_pkg::res_t
//   APB          in         psel/penable/pready   seg_mode @0x0, pretrigger_count @0x4
//
// A transaction produces n results, n from 1 to 64: accept, a multiply step and
// a correction step for the segment split, then one address per cycle from the
// offset counters while the output register is free.
// in_stall stays high from acceptance until the final result is loaded.
// A stalled output holds the sequencer; reset clears state and output valid.
module segmented_capture_readout_address (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  scra_pkg::req_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output scra_pkg::res_t                 out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scra_pkg::PADDR_W-1:0]   paddr,
  input  logic [scra_pkg::PDATA_W-1:0]   pwdata,
  output logic [scra_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [scra_pkg::MODE_W-1:0] seg_mode;
  logic [scra_pkg::PRE_W-1:0]  pretrigger_count;
  scra_pkg::ctrl_cmd_t         cmd;
  scra_pkg::dp_status_t        status;

  assign pready = 1'b1;

  scra_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .seg_mode         (seg_mode),
    .pretrigger_count (pretrigger_count)
  );

  scra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  scra_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_data          (in_data),
    .seg_mode         (seg_mode),
    .pretrigger_count (pretrigger_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule

@@ test/segmented_capture_readout_address_checker.sv @@
// Checker for the readout address generator: predicts each request's addresses and compares.
`timescale 1ns / 100ps

module segmented_capture_readout_address_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  scra_pkg::req_t                in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  scra_pkg::res_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [scra_pkg::PADDR_W-1:0]  paddr,
  input  logic [scra_pkg::PDATA_W-1:0]  pwdata,
  output int                            fail_count,
  output int                            pending,
  output int                            req_count,
  output int                            addr_count,
  output int                            limit_count,
  output int                            empty_count
);

  logic [scra_pkg::MODE_W-1:0] seg_mode_now;
  int                          pretrigger_now;
  scra_pkg::res_t              due_results[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    req_count   = 0;
    addr_count  = 0;
    limit_count = 0;
    empty_count = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void predict_readout(input scra_pkg::req_t r);
    int             base, offset, budget, cap, sps, lim, n;
    bit             at_limit;
    scra_pkg::res_t one;
    scra_pkg::res_t batch[$];
    base   = (int'(r.trigger_location) + scra_pkg::BUFFER_DEPTH - pretrigger_now) %
             scra_pkg::BUFFER_DEPTH;
    budget = (int'(r.max_words) > scra_pkg::MAX_WORDS) ? scra_pkg::MAX_WORDS :
             int'(r.max_words);
    offset = int'(r.start_offset);
    at_limit = 1'b0;
    if (seg_mode_now == scra_pkg::MODE_CONTIG) begin
      cap = scra_pkg::BUFFER_DEPTH;
      sps = scra_pkg::CONTIG_LIMIT;
      lim = scra_pkg::CONTIG_LIMIT;
    end else begin
      cap = (seg_mode_now == scra_pkg::MODE_LONG) ? scra_pkg::LONG_SEG_DEPTH :
            scra_pkg::SHORT_SEG_DEPTH;
      sps = cap - scra_pkg::LATENCY_LOSS;
      lim = sps * (scra_pkg::BUFFER_DEPTH / cap);
    end
    n = 0;
    while (n < budget && offset < int'(r.end_offset)) begin
      if (offset >= lim) begin
        at_limit = 1'b1;
        break;
      end
      one.read_address = scra_pkg::ADDR_W'((base + (offset / sps) * cap + offset % sps) %
                                           scra_pkg::BUFFER_DEPTH);
      one.addr_valid   = 1'b1;
      one.beyond_limit = 1'b0;
      one.last_result  = 1'b0;
      batch.push_back(one);
      n++;
      offset++;
    end
    if (n == 0) begin
      one = '0;
      one.beyond_limit = at_limit;
      one.last_result  = 1'b1;
      batch.push_back(one);
      empty_count++;
    end else begin
      one = batch[n-1];
      one.beyond_limit = at_limit;
      one.last_result  = 1'b1;
      batch[n-1] = one;
    end
    if (at_limit) limit_count++;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin : watch
    int                           v;
    logic [scra_pkg::PADDR_W-1:0] reg_sel;
    scra_pkg::res_t               want;
    if (rst) begin
      seg_mode_now   = scra_pkg::MODE_CONTIG;
      pretrigger_now = 1;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_sel = paddr >> 2;
        if (reg_sel == scra_pkg::PADDR_W'(scra_pkg::REG_SEG_MODE)) begin
          seg_mode_now = pwdata[scra_pkg::MODE_W-1:0];
        end else if (reg_sel == scra_pkg::PADDR_W'(scra_pkg::REG_PRETRIGGER)) begin
          v = int'(pwdata[scra_pkg::PRE_W-1:0]);
          if (v == 0) v = 1;
          if (v > scra_pkg::PRE_MAX) v = scra_pkg::PRE_MAX;
          pretrigger_now = v;
        end
      end
      if (in_valid && !in_stall) begin
        predict_readout(in_data);
        req_count++;
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result, address", out_data.read_address, 0);
        end else begin
          want = due_results.pop_front();
          if (out_data.read_address !== want.read_address)
            report_mismatch("read_address", out_data.read_address, want.read_address);
          if (out_data.addr_valid !== want.addr_valid)
            report_mismatch("addr_valid", out_data.addr_valid, want.addr_valid);
          if (out_data.beyond_limit !== want.beyond_limit)
            report_mismatch("beyond_limit", out_data.beyond_limit, want.beyond_limit);
          if (out_data.last_result !== want.last_result)
            report_mismatch("last_result", out_data.last_result, want.last_result);
          if (want.addr_valid) addr_count++;
        end
      end
    end
    pending = due_results.size();
  end

endmodule

@@ test/segmented_capture_readout_address_test.sv @@
// Stimulus, register setup and verdict for the readout address generator.
`timescale 1ns / 100ps

module segmented_capture_readout_address_test;

  localparam logic [scra_pkg::MODE_W-1:0] MODE_SHORT     = 2'd2;
  localparam logic [scra_pkg::MODE_W-1:0] MODE_SHORT_ALT = 2'd3;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 55;
  localparam int HOLD_CYCLES = 400;
  localparam int END_MAX     = scra_pkg::BUFFER_DEPTH;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  scra_pkg::req_t               in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  scra_pkg::res_t               out_data;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [scra_pkg::PADDR_W-1:0] paddr     = '0;
  logic [scra_pkg::PDATA_W-1:0] pwdata    = '0;
  logic [scra_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  int             fail_count, pending, req_count, addr_count, limit_count, empty_count;
  int             stall_style = 0;
  bit             long_hold   = 1'b0;
  bit             gaps_on     = 1'b0;
  scra_pkg::req_t batch[$];

  always #5 clk = ~clk;

  segmented_capture_readout_address dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  segmented_capture_readout_address_checker readout_check (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending, .req_count, .addr_count, .limit_count, .empty_count
  );

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : receiver
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        case (stall_style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 35);
          default: out_stall <= ((cyc % 11) < 4);
        endcase
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [scra_pkg::PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= scra_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_req(input int trig, input int first, input int stop, input int words);
    scra_pkg::req_t r;
    r.trigger_location = scra_pkg::ADDR_W'(trig);
    r.start_offset     = scra_pkg::START_W'(first);
    r.end_offset       = scra_pkg::OFF_W'(stop);
    r.max_words        = scra_pkg::WORDS_W'(words);
    batch.push_back(r);
  endtask

  task automatic send_batch();
    int burst;
    bit took;
    @(posedge clk);
    burst = $urandom_range(1, 12);
    foreach (batch[i]) begin
      in_valid <= 1'b1;
      in_data  <= batch[i];
      do begin
        @(negedge clk);
        took = !in_stall;
        @(posedge clk);
      end while (!took);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if (gaps_on) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    batch.delete();
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [scra_pkg::MODE_W-1:0]  mode;
    logic [scra_pkg::PDATA_W-1:0] word;
    int cap, sps, lim, first, stop, words;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: contiguous, one pretrigger sample
    add_req(0, 0, 5, 4);
    add_req(32767, 32767, 32768, 64);
    add_req(100, 10, 10, 10);
    add_req(200, 0, 20, 0);
    add_req(32767, 0, 32768, 127);
    add_req(4000, 32750, 32768, 64);
    add_req(17, 32753, 32768, 1);
    add_req(21845, 100, 50, 64);
    send_batch();

    write_reg(scra_pkg::REG_SEG_MODE, scra_pkg::PDATA_W'(scra_pkg::MODE_LONG));
    write_reg(scra_pkg::REG_PRETRIGGER, 32'hFFFF_7FFF);
    add_req(10922, 4080, 4090, 20);
    add_req(1, 32650, 32700, 64);
    add_req(5, 0, 3, 3);
    add_req(32767, 32656, 32768, 64);
    send_batch();

    write_reg(scra_pkg::REG_SEG_MODE, scra_pkg::PDATA_W'(MODE_SHORT));
    write_reg(scra_pkg::REG_PRETRIGGER, 32'h0001_8000);
    add_req(0, 1005, 1015, 64);
    add_req(30000, 32318, 32768, 64);
    add_req(123, 32767, 32768, 127);
    send_batch();

    write_reg(scra_pkg::REG_SEG_MODE, scra_pkg::PDATA_W'(MODE_SHORT_ALT));
    write_reg(scra_pkg::REG_PRETRIGGER, scra_pkg::PDATA_W'(scra_pkg::PRE_MAX));
    add_req(3, 1008, 1013, 5);
    add_req(32767, 0, 32768, 64);
    send_batch();

    for (int p = 0; p < PHASES; p++) begin
      mode = scra_pkg::MODE_W'(p % 4);
      word = $urandom();
      word[scra_pkg::MODE_W-1:0] = mode;
      write_reg(scra_pkg::REG_SEG_MODE, word);
      case ($urandom_range(0, 3))
        0:       word = '0;
        1:       word = '1;
        2:       word = $urandom();
        default: word = scra_pkg::PDATA_W'($urandom_range(1, 200));
      endcase
      write_reg(scra_pkg::REG_PRETRIGGER, word);

      stall_style = p % 3;
      gaps_on     = (p != 0);
      if (p == 3) long_hold = 1'b1;

      if (mode == scra_pkg::MODE_CONTIG) begin
        cap = scra_pkg::BUFFER_DEPTH;
        sps = scra_pkg::CONTIG_LIMIT;
      end else begin
        cap = (mode == scra_pkg::MODE_LONG) ? scra_pkg::LONG_SEG_DEPTH :
              scra_pkg::SHORT_SEG_DEPTH;
        sps = cap - scra_pkg::LATENCY_LOSS;
      end
      lim = sps * (scra_pkg::BUFFER_DEPTH / cap);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            first = $urandom_range(0, lim - 1);
            stop  = first + $urandom_range(0, 70);
          end
          4, 5: begin
            first = sps * $urandom_range(1, scra_pkg::BUFFER_DEPTH / cap) -
                    $urandom_range(0, 40);
            stop  = first + $urandom_range(0, 80);
          end
          6: begin
            first = $urandom_range(lim - 10, 32767);
            stop  = ($urandom_range(0, 1) == 0) ? END_MAX : first + $urandom_range(0, 20);
          end
          7: begin
            first = $urandom_range(0, 32767);
            stop  = $urandom_range(0, END_MAX);
          end
          8: begin
            first = $urandom_range(0, 32767);
            stop  = $urandom_range(0, first);
          end
          default: begin
            first = $urandom_range(0, 32767);
            stop  = END_MAX;
          end
        endcase
        if (stop > END_MAX) stop = END_MAX;
        case ($urandom_range(0, 9))
          0:       words = 0;
          1:       words = $urandom_range(scra_pkg::MAX_WORDS, 127);
          default: words = $urandom_range(1, 24);
        endcase
        add_req($urandom(), first, stop, words);
      end
      send_batch();
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d readout requests and %0d checked addresses over all four modes.",
             req_count, addr_count);
    $display("%0d requests stopped at the mode limit, %0d produced no address.",
             limit_count, empty_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ segmented_capture_readout_address.f @@
sv/scra_pkg.sv
sv/scra_regs.sv
sv/scra_ctrl.sv
sv/scra_dp.sv
sv/segmented_capture_readout_address.sv
test/segmented_capture_readout_address_checker.sv
test/segmented_capture_readout_address_test.sv
